@@ src/bsc_pkg.sv @@
package bsc_pkg;

	localparam int MAX_PLANES = 8;
	localparam int PW = $clog2(MAX_PLANES + 1);
	localparam int PIW = $clog2(MAX_PLANES);
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int ODEPTH = 2;
	localparam int OAW = $clog2(ODEPTH);

	localparam logic [31:0] EPS_RESET = 32'h358637BD;
	localparam logic [31:0] FP_QNAN = 32'h7FC00000;

	localparam logic [1:0] CMD_FIRST = 2'd0;
	localparam logic [1:0] CMD_SECOND = 2'd1;
	localparam logic [1:0] CMD_TEST = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [1:0] CLS_INSIDE = 2'd0;
	localparam logic [1:0] CLS_OVERLAP = 2'd1;
	localparam logic [1:0] CLS_OUTSIDE = 2'd2;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	typedef logic [31:0] f32_t;

	typedef struct packed {
		logic [1:0] cmd;
		f32_t [5:0] box;
	} item_t;

	typedef struct packed {
		f32_t [2:0] n;
		f32_t d;
		logic [2:0] hi;
	} plane_t;

	// intermediate float: w[49] weighs 2^(ex-127)
	typedef struct packed {
		logic sgn;
		logic signed [10:0] ex;
		logic [49:0] w;
		logic spec;
		f32_t sval;
	} fp_mid_t;

	function automatic logic fp_is_nan(f32_t a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic fp_is_inf(f32_t a);
		return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	endfunction

	function automatic logic fp_is_zero(f32_t a);
		return a[30:0] == 31'd0;
	endfunction

	function automatic logic fp_gt(f32_t a, f32_t b);
		logic [31:0] ka;
		logic [31:0] kb;
		ka = a[31] ? ~a : {1'b1, a[30:0]};
		kb = b[31] ? ~b : {1'b1, b[30:0]};
		if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_zero(a) && fp_is_zero(b)))
			return 1'b0;
		return ka > kb;
	endfunction

	function automatic logic fp_eq(f32_t a, f32_t b);
		if (fp_is_nan(a) || fp_is_nan(b))
			return 1'b0;
		return (a == b) || (fp_is_zero(a) && fp_is_zero(b));
	endfunction

	function automatic logic fp_le(f32_t a, f32_t b);
		return fp_gt(b, a) || fp_eq(a, b);
	endfunction

	function automatic f32_t fp_abs(f32_t a);
		return {1'b0, a[30:0]};
	endfunction

	function automatic f32_t fp_neg(f32_t a);
		return {~a[31], a[30:0]};
	endfunction

	function automatic logic fp_disjoint(f32_t [5:0] a, f32_t [5:0] b);
		logic r;
		r = 1'b0;
		for (int k = 0; k < 3; k++)
			if (fp_gt(a[k], b[k + 3]) || fp_gt(b[k], a[k + 3]))
				r = 1'b1;
		return r;
	endfunction

	// unpack, multiply or align and add
	function automatic fp_mid_t fp_stage1(logic [1:0] op, f32_t a, f32_t b);
		fp_mid_t r;
		f32_t bb;
		f32_t l;
		f32_t s;
		logic [7:0] ea;
		logic [7:0] eb;
		logic [23:0] ma;
		logic [23:0] mb;
		logic [47:0] p;
		logic [7:0] d;
		logic [49:0] wl;
		logic [49:0] wsf;
		logic [49:0] ws;
		logic st;
		r = '0;
		if (op == OP_MUL) begin
			ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
			eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
			ma = {a[30:23] != 8'd0, a[22:0]};
			mb = {b[30:23] != 8'd0, b[22:0]};
			r.sgn = a[31] ^ b[31];
			p = ma * mb;
			r.w = {p, 2'b00};
			r.ex = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
			if (fp_is_nan(a) || fp_is_nan(b)) begin
				r.spec = 1'b1;
				r.sval = FP_QNAN;
			end else if (fp_is_inf(a) || fp_is_inf(b)) begin
				r.spec = 1'b1;
				r.sval = (fp_is_zero(a) || fp_is_zero(b)) ? FP_QNAN : {r.sgn, 31'h7F800000};
			end
		end else begin
			bb = (op == OP_SUB) ? fp_neg(b) : b;
			if (a[30:0] < bb[30:0]) begin
				l = bb;
				s = a;
			end else begin
				l = a;
				s = bb;
			end
			ea = (l[30:23] == 8'd0) ? 8'd1 : l[30:23];
			eb = (s[30:23] == 8'd0) ? 8'd1 : s[30:23];
			ma = {l[30:23] != 8'd0, l[22:0]};
			mb = {s[30:23] != 8'd0, s[22:0]};
			d = ea - eb;
			wl = {1'b0, ma, 25'd0};
			wsf = {1'b0, mb, 25'd0};
			if (d >= 8'd50) begin
				ws = 50'd0;
				st = mb != 24'd0;
			end else begin
				ws = wsf >> d;
				st = (wsf & ((50'd1 << d) - 50'd1)) != 50'd0;
			end
			ws[0] = ws[0] | st;
			r.w = (l[31] != s[31]) ? (wl - ws) : (wl + ws);
			r.sgn = (r.w == 50'd0) ? (l[31] & s[31]) : l[31];
			r.ex = $signed({3'b000, ea}) + 11'sd1;
			if (fp_is_nan(a) || fp_is_nan(bb)) begin
				r.spec = 1'b1;
				r.sval = FP_QNAN;
			end else if (fp_is_inf(a) && fp_is_inf(bb) && (a[31] != bb[31])) begin
				r.spec = 1'b1;
				r.sval = FP_QNAN;
			end else if (fp_is_inf(a)) begin
				r.spec = 1'b1;
				r.sval = a;
			end else if (fp_is_inf(bb)) begin
				r.spec = 1'b1;
				r.sval = bb;
			end
		end
		return r;
	endfunction

	// leading-one alignment, subnormal denormalization
	function automatic fp_mid_t fp_norm(fp_mid_t m);
		fp_mid_t r;
		logic [5:0] lz;
		logic signed [10:0] e2;
		logic signed [10:0] shn;
		logic [5:0] sh;
		logic lost;
		r = m;
		lz = 6'd0;
		for (int i = 0; i < 50; i++)
			if (m.w[i])
				lz = 6'(49 - i);
		e2 = m.ex - $signed({5'd0, lz});
		shn = 11'sd1 - m.ex;
		sh = shn[5:0];
		lost = 1'b0;
		if (!m.spec && (m.w != 50'd0)) begin
			if (e2 >= 11'sd1) begin
				r.w = m.w << lz;
				r.ex = e2;
			end else if (m.ex >= 11'sd1) begin
				r.w = m.w << 6'(m.ex - 11'sd1);
				r.ex = 11'sd1;
			end else begin
				if (shn >= 11'sd50) begin
					r.w = 50'd1;
				end else begin
					lost = (m.w & ((50'd1 << sh) - 50'd1)) != 50'd0;
					r.w = (m.w >> sh) | {49'd0, lost};
				end
				r.ex = 11'sd1;
			end
		end
		return r;
	endfunction

	// round to nearest even and pack
	function automatic f32_t fp_round(fp_mid_t m);
		logic [23:0] mant;
		logic inc;
		logic [24:0] r25;
		logic [33:0] pk;
		mant = m.w[49:26];
		inc = m.w[25] & ((m.w[24:0] != 25'd0) | mant[0]);
		r25 = {1'b0, mant} + {24'd0, inc};
		pk = (34'(m.ex - 11'sd1) << 23) + {9'd0, r25};
		if (m.spec)
			return m.sval;
		if (m.w == 50'd0)
			return {m.sgn, 31'd0};
		if (pk >= (34'd255 << 23))
			return {m.sgn, 31'h7F800000};
		return {m.sgn, pk[30:0]};
	endfunction

endpackage

@@ src/bsc_front.sv @@
module bsc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  bsc_pkg::item_t in_item,
	output logic           out_valid,
	output bsc_pkg::item_t out_item,
	input  logic           out_take
);
	import bsc_pkg::*;

	item_t q_mem [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0] cnt_q;
	logic acc;
	logic keep;

	assign full = cnt_q == (QAW+1)'(QDEPTH);
	assign acc = push && !full;
	// beats with an unused command are taken and dropped here
	assign keep = acc && (in_item.cmd != CMD_NONE);
	assign out_valid = cnt_q != '0;
	assign out_item = q_mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (keep)
				wr_q <= wr_q + 1'b1;
			if (out_take)
				rd_q <= rd_q + 1'b1;
			if (keep && !out_take)
				cnt_q <= cnt_q + 1'b1;
			else if (!keep && out_take)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (keep)
			q_mem[wr_q] <= in_item;
	end

endmodule

@@ src/bsc_fpu.sv @@
module bsc_fpu (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [1:0]    op,
	input  bsc_pkg::f32_t a,
	input  bsc_pkg::f32_t b,
	output logic          done,
	output bsc_pkg::f32_t res
);
	import bsc_pkg::*;

	logic v_s1, v_s2, v_s3;
	fp_mid_t m_s1, m_s2;
	f32_t r_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		m_s1 <= fp_stage1(op, a, b);
		m_s2 <= fp_norm(m_s1);
		r_s3 <= fp_round(m_s2);
	end

	assign done = v_s3;
	assign res = r_s3;

endmodule

@@ src/bsc_back.sv @@
module bsc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  bsc_pkg::f32_t  eps,
	input  logic           in_valid,
	input  bsc_pkg::item_t in_item,
	output logic           in_take,
	output logic           res_valid,
	output logic [1:0]     res_class,
	input  logic           res_ready
);
	import bsc_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_OWN = 3'd1;
	localparam logic [2:0] ST_PAIR = 3'd2;
	localparam logic [2:0] ST_PLANE = 3'd3;
	localparam logic [2:0] ST_TEST = 3'd4;
	localparam logic [2:0] ST_RES = 3'd5;

	logic [2:0] st_q;
	f32_t [5:0] first_q, second_q, ext_q, box_q;
	logic [5:0] own1_q, own2_q;
	plane_t planes_q [MAX_PLANES];
	logic [PW-1:0] cnt_q, pidx_q;
	logic [2:0] ii_q, jj_q, step_q;
	logic pass_q, pend_q;
	f32_t du_q, dv_q, acc_q, t_q, tol_q;
	logic [1:0] cls_q;

	logic go, need, fdone, tend, same, fw, pair_ok, pair_last, hit, plane_we;
	logic [1:0] fop, ax_a, ax_b;
	f32_t fa, fb, fres, u1, u2, v1, v2;
	f32_t [2:0] cv;
	plane_t pl, np;
	logic [2:0] nii, njj;

	bsc_fpu u_fpu (
		.clk(clk), .arst_n(arst_n), .go(go), .op(fop), .a(fa), .b(fb),
		.done(fdone), .res(fres)
	);

	assign u1 = first_q[ii_q];
	assign v1 = first_q[jj_q];
	assign u2 = second_q[ii_q];
	assign v2 = second_q[jj_q];
	assign same = (ii_q >= 3'd3) == (jj_q >= 3'd3);
	assign ax_a = (ii_q >= 3'd3) ? 2'(ii_q - 3'd3) : ii_q[1:0];
	assign ax_b = (jj_q >= 3'd3) ? 2'(jj_q - 3'd3) : jj_q[1:0];
	assign pair_ok = own1_q[ii_q] && own2_q[jj_q] && (ax_a != ax_b);
	assign pair_last = (ii_q == 3'd5) && (jj_q == 3'd5);
	assign nii = (jj_q == 3'd5) ? ii_q + 3'd1 : ii_q;
	assign njj = (jj_q == 3'd5) ? 3'd0 : jj_q + 3'd1;
	assign fw = (ii_q < 3'd3) ? fp_gt(u2, u1) : fp_gt(u1, u2);

	assign pl = planes_q[pidx_q[PIW-1:0]];
	assign tend = (step_q == 3'd0) && (pidx_q == cnt_q);
	assign hit = pass_q ? fp_gt(fres, fp_abs(tol_q)) : fp_gt(fres, fp_neg(fp_abs(tol_q)));

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cv[k] = box_q[3'(k) + ((pl.hi[k] ^ pass_q) ? 3'd3 : 3'd0)];
			np.n[k] = (2'(k) == ax_a) ? du_q : ((2'(k) == ax_b) ? dv_q : 32'd0);
			np.hi[k] = !fp_gt(np.n[k], 32'd0);
		end
		np.d = fp_neg(fres);
	end

	always_comb begin
		need = 1'b0;
		fop = OP_ADD;
		fa = acc_q;
		fb = t_q;
		unique case (st_q)
			ST_OWN: begin
				need = 1'b1;
				fop = OP_SUB;
				fa = u1;
				fb = u2;
			end
			ST_PLANE: begin
				need = 1'b1;
				case (step_q)
					3'd0: begin
						fop = OP_SUB;
						fa = same ? v2 : v1;
						fb = same ? v1 : v2;
					end
					3'd1: begin
						fop = OP_SUB;
						fa = same ? u1 : u2;
						fb = same ? u2 : u1;
					end
					3'd2: begin
						fop = OP_MUL;
						fa = du_q;
						fb = u1;
					end
					3'd3: begin
						fop = OP_MUL;
						fa = dv_q;
						fb = v1;
					end
					default: ;
				endcase
			end
			ST_TEST: begin
				need = !tend;
				case (step_q)
					3'd0: begin
						fop = OP_MUL;
						fa = pl.d;
						fb = eps;
					end
					3'd1: begin
						fop = OP_MUL;
						fa = pl.n[0];
						fb = cv[0];
					end
					3'd2: begin
						fop = OP_MUL;
						fa = pl.n[1];
						fb = cv[1];
					end
					3'd4: begin
						fop = OP_MUL;
						fa = pl.n[2];
						fb = cv[2];
					end
					3'd6: begin
						fb = pl.d;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign go = need && !pend_q;
	assign in_take = (st_q == ST_IDLE) && in_valid;
	assign res_valid = st_q == ST_RES;
	assign res_class = cls_q;
	assign plane_we = (st_q == ST_PLANE) && fdone && (step_q == 3'd4);

	always_ff @(posedge clk) begin
		if (plane_we)
			planes_q[cnt_q[PIW-1:0]] <= np;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			first_q <= '0;
			second_q <= '0;
			ext_q <= '0;
			box_q <= '0;
			own1_q <= '0;
			own2_q <= '0;
			cnt_q <= '0;
			pidx_q <= '0;
			ii_q <= '0;
			jj_q <= '0;
			step_q <= '0;
			pass_q <= 1'b0;
			pend_q <= 1'b0;
			du_q <= '0;
			dv_q <= '0;
			acc_q <= '0;
			t_q <= '0;
			tol_q <= '0;
			cls_q <= CLS_INSIDE;
		end else begin
			if (go)
				pend_q <= 1'b1;
			else if (fdone)
				pend_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (in_item.cmd)
							CMD_FIRST: first_q <= in_item.box;
							CMD_SECOND: begin
								second_q <= in_item.box;
								ii_q <= '0;
								cnt_q <= '0;
								st_q <= ST_OWN;
							end
							CMD_TEST: begin
								box_q <= in_item.box;
								if (fp_disjoint(in_item.box, ext_q)) begin
									cls_q <= CLS_OUTSIDE;
									st_q <= ST_RES;
								end else begin
									pidx_q <= '0;
									pass_q <= 1'b0;
									step_q <= '0;
									st_q <= ST_TEST;
								end
							end
							default: ;
						endcase
					end
				end
				ST_OWN: begin
					if (fdone) begin
						own1_q[ii_q] <= fw;
						own2_q[ii_q] <= !fw && !fp_le(fp_abs(fres), eps);
						ext_q[ii_q] <= fw ? u1 : u2;
						if (ii_q == 3'd5) begin
							ii_q <= '0;
							jj_q <= '0;
							st_q <= ST_PAIR;
						end else begin
							ii_q <= ii_q + 3'd1;
						end
					end
				end
				ST_PAIR: begin
					if (pair_ok) begin
						if (cnt_q == PW'(MAX_PLANES)) begin
							st_q <= ST_IDLE;
						end else begin
							step_q <= '0;
							st_q <= ST_PLANE;
						end
					end else if (pair_last) begin
						st_q <= ST_IDLE;
					end else begin
						ii_q <= nii;
						jj_q <= njj;
					end
				end
				ST_PLANE: begin
					if (fdone) begin
						step_q <= step_q + 3'd1;
						case (step_q)
							3'd0: du_q <= fres;
							3'd1: dv_q <= fres;
							3'd2: acc_q <= fres;
							3'd3: t_q <= fres;
							default: begin
								cnt_q <= cnt_q + 1'b1;
								if (pair_last) begin
									st_q <= ST_IDLE;
								end else begin
									ii_q <= nii;
									jj_q <= njj;
									st_q <= ST_PAIR;
								end
							end
						endcase
					end
				end
				ST_TEST: begin
					if (tend && !pend_q) begin
						if (pass_q) begin
							cls_q <= CLS_INSIDE;
							st_q <= ST_RES;
						end else if (!fp_disjoint(box_q, first_q) ||
						             !fp_disjoint(box_q, second_q)) begin
							cls_q <= CLS_OVERLAP;
							st_q <= ST_RES;
						end else begin
							pass_q <= 1'b1;
							pidx_q <= '0;
						end
					end else if (fdone) begin
						case (step_q)
							3'd0: begin
								tol_q <= fres;
								step_q <= step_q + 3'd1;
							end
							3'd2, 3'd4: begin
								t_q <= fres;
								step_q <= step_q + 3'd1;
							end
							3'd1, 3'd3, 3'd5: begin
								acc_q <= fres;
								step_q <= step_q + 3'd1;
							end
							default: begin
								step_q <= '0;
								if (hit) begin
									cls_q <= pass_q ? CLS_OVERLAP : CLS_OUTSIDE;
									st_q <= ST_RES;
								end else begin
									pidx_q <= pidx_q + 1'b1;
								end
							end
						endcase
					end
				end
				ST_RES: begin
					if (res_ready)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_pend: assert property (@(posedge clk) disable iff (!arst_n)
		fdone |-> pend_q) else $error("fpu result without a request");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= PW'(MAX_PLANES)) else $error("plane count overflow");
	a_build_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && in_item.cmd == CMD_SECOND) |=> (st_q == ST_OWN && cnt_q == '0))
		else $error("build did not start");
	a_res_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (cls_q == CLS_INSIDE || cls_q == CLS_OVERLAP || cls_q == CLS_OUTSIDE))
		else $error("bad class code");
`endif

endmodule

@@ src/box_shaft_cull_test.sv @@
// Shaft culling of a test box against the shaft between two reference boxes, all in IEEE
// single precision with full subnormal support. Beats enter through a 4-deep input queue
// (push/full) and a class leaves through a 2-deep result queue (empty/pop); only test
// commands produce a result. All float arithmetic goes through one shared add/multiply unit,
// which takes a new operation only after the previous result has returned. A second-box
// load builds the shaft (up to 8 planes), and a test is either rejected by the extent or
// visits the planes in at most two passes.
module box_shaft_cull_test (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [31:0] box_min_x,
	input  logic [31:0] box_min_y,
	input  logic [31:0] box_min_z,
	input  logic [31:0] box_max_x,
	input  logic [31:0] box_max_y,
	input  logic [31:0] box_max_z,
	input  logic        eps_we,
	input  logic [31:0] eps_wdata,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  side_class
);
	import bsc_pkg::*;

	f32_t eps_q;
	item_t in_item, q_item;
	logic q_valid, q_take, res_valid, res_ready;
	logic [1:0] res_class;
	logic [1:0] oq_q [ODEPTH];
	logic [OAW-1:0] owr_q, ord_q;
	logic [OAW:0] ocnt_q;
	logic opush, opop;

	assign in_item.cmd = cmd;
	assign in_item.box = {box_max_z, box_max_y, box_max_x, box_min_z, box_min_y, box_min_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			eps_q <= EPS_RESET;
		else if (eps_we)
			eps_q <= eps_wdata;
	end

	bsc_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.out_valid(q_valid), .out_item(q_item), .out_take(q_take)
	);

	bsc_back u_back (
		.clk(clk), .arst_n(arst_n), .eps(eps_q), .in_valid(q_valid), .in_item(q_item),
		.in_take(q_take), .res_valid(res_valid), .res_class(res_class),
		.res_ready(res_ready)
	);

	assign res_ready = ocnt_q != (OAW+1)'(ODEPTH);
	assign opush = res_valid && res_ready;
	assign opop = pop && !empty;
	assign empty = ocnt_q == '0;
	assign side_class = oq_q[ord_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q <= '0;
			ord_q <= '0;
			ocnt_q <= '0;
		end else begin
			if (opush)
				owr_q <= owr_q + 1'b1;
			if (opop)
				ord_q <= ord_q + 1'b1;
			if (opush && !opop)
				ocnt_q <= ocnt_q + 1'b1;
			else if (!opush && opop)
				ocnt_q <= ocnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (opush)
			oq_q[owr_q] <= res_class;
	end

endmodule

@@ verif/box_shaft_cull_test_tb.sv @@
`timescale 1ns / 100ps

module box_shaft_cull_test_tb;
	import bsc_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int SETTLE = 1500;

	typedef logic [31:0] fbits_t;

	typedef struct {
		logic [1:0] c;
		fbits_t b[6];
		bit typed;
		logic [1:0] cls;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [1:0] cmd = CMD_NONE;
	logic [31:0] box_min_x = '0, box_min_y = '0, box_min_z = '0;
	logic [31:0] box_max_x = '0, box_max_y = '0, box_max_z = '0;
	logic eps_we = 1'b0;
	logic [31:0] eps_wdata = '0;
	logic empty;
	logic pop = 1'b0;
	logic [1:0] side_class;

	box_shaft_cull_test uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
		.box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
		.eps_we(eps_we), .eps_wdata(eps_wdata), .empty(empty), .pop(pop),
		.side_class(side_class)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shaft model state
	fbits_t tol_bits;
	fbits_t ref_a[6], ref_b[6], hull[6];
	fbits_t pl_n[MAX_PLANES][4];
	int pl_sel[MAX_PLANES][3];
	int pl_cnt;

	logic [1:0] class_q[$];
	bit failed = 1'b0;
	bit hold_req = 1'b0;
	bit no_idle = 1'b0;
	int quiet = 0;

	// ---- single precision arithmetic ----
	function automatic bit sp_nan(fbits_t a);
		return a[30:23] == 8'hFF && a[22:0] != 0;
	endfunction

	function automatic bit sp_inf(fbits_t a);
		return a[30:23] == 8'hFF && a[22:0] == 0;
	endfunction

	function automatic fbits_t sp_pack(bit s, logic [127:0] sig, int e2);
		int p, ex, sh;
		logic [127:0] m, rem, half;
		longint pk;
		if (sig == 0)
			return {s, 31'd0};
		p = 0;
		for (int i = 0; i < 128; i++)
			if (sig[i])
				p = i;
		ex = p + e2 + 127;
		if (ex < 1)
			ex = 1;
		sh = ex - 150 - e2;
		if (sh <= 0) begin
			m = sig << (-sh);
		end else if (sh >= 128) begin
			m = 0;
		end else begin
			m = sig >> sh;
			rem = sig & ((128'd1 << sh) - 1);
			half = 128'd1 << (sh - 1);
			if (rem > half || (rem == half && m[0]))
				m = m + 1;
		end
		pk = (longint'(ex - 1) <<< 23) + longint'(m[63:0]);
		if (pk >= (longint'(255) <<< 23))
			return {s, 31'h7F800000};
		return {s, pk[30:0]};
	endfunction

	function automatic int sp_exp(fbits_t a);
		return (a[30:23] == 0) ? 1 : int'(a[30:23]);
	endfunction

	function automatic logic [23:0] sp_man(fbits_t a);
		return {a[30:23] != 0, a[22:0]};
	endfunction

	function automatic fbits_t sp_mul(fbits_t a, fbits_t b);
		logic [127:0] pr;
		bit s;
		s = a[31] ^ b[31];
		if (sp_nan(a) || sp_nan(b))
			return FP_QNAN;
		if (sp_inf(a) || sp_inf(b))
			return (a[30:0] == 0 || b[30:0] == 0) ? FP_QNAN : {s, 31'h7F800000};
		pr = 128'(sp_man(a)) * 128'(sp_man(b));
		return sp_pack(s, pr, sp_exp(a) + sp_exp(b) - 300);
	endfunction

	function automatic fbits_t sp_add(fbits_t a, fbits_t b);
		int ea, eb, e;
		logic signed [127:0] va, vb, sum;
		if (sp_nan(a) || sp_nan(b))
			return FP_QNAN;
		if (sp_inf(a) && sp_inf(b) && a[31] != b[31])
			return FP_QNAN;
		if (sp_inf(a))
			return a;
		if (sp_inf(b))
			return b;
		ea = sp_exp(a);
		eb = sp_exp(b);
		if (ea - eb > 60)
			return a;
		if (eb - ea > 60)
			return b;
		e = (ea < eb) ? ea : eb;
		va = 128'(sp_man(a)) << (ea - e);
		vb = 128'(sp_man(b)) << (eb - e);
		if (a[31])
			va = -va;
		if (b[31])
			vb = -vb;
		sum = va + vb;
		if (sum == 0)
			return {a[31] & b[31], 31'd0};
		if (sum < 0)
			return sp_pack(1'b1, -sum, e - 150);
		return sp_pack(1'b0, sum, e - 150);
	endfunction

	function automatic fbits_t sp_neg(fbits_t a);
		return {~a[31], a[30:0]};
	endfunction

	function automatic fbits_t sp_abs(fbits_t a);
		return {1'b0, a[30:0]};
	endfunction

	function automatic bit sp_gt(fbits_t a, fbits_t b);
		logic [31:0] ka, kb;
		if (sp_nan(a) || sp_nan(b) || (a[30:0] == 0 && b[30:0] == 0))
			return 1'b0;
		ka = a[31] ? ~a : {1'b1, a[30:0]};
		kb = b[31] ? ~b : {1'b1, b[30:0]};
		return ka > kb;
	endfunction

	function automatic bit sp_le(fbits_t a, fbits_t b);
		if (sp_nan(a) || sp_nan(b))
			return 1'b0;
		return sp_gt(b, a) || a == b || (a[30:0] == 0 && b[30:0] == 0);
	endfunction

	function automatic bit apart(fbits_t a[6], fbits_t b[6]);
		for (int k = 0; k < 3; k++)
			if (sp_gt(a[k], b[k + 3]) || sp_gt(b[k], a[k + 3]))
				return 1'b1;
		return 1'b0;
	endfunction

	// ---- shaft construction and classification ----
	task automatic build_shaft();
		bit own1[6], own2[6];
		int a, b;
		fbits_t du, dv, p, nv[3];
		for (int i = 0; i < 6; i++) begin
			own1[i] = (i < 3) ? sp_gt(ref_b[i], ref_a[i]) : sp_gt(ref_a[i], ref_b[i]);
			own2[i] = 1'b0;
			if (own1[i]) begin
				hull[i] = ref_a[i];
			end else begin
				hull[i] = ref_b[i];
				own2[i] = !sp_le(sp_abs(sp_add(ref_a[i], sp_neg(ref_b[i]))), tol_bits);
			end
		end
		pl_cnt = 0;
		for (int i = 0; i < 6; i++) begin
			if (!own1[i])
				continue;
			for (int j = 0; j < 6; j++) begin
				a = i % 3;
				b = j % 3;
				if (!own2[j] || a == b)
					continue;
				if (pl_cnt >= MAX_PLANES)
					return;
				if ((i < 3) == (j < 3)) begin
					du = sp_add(ref_b[j], sp_neg(ref_a[j]));
					dv = sp_add(ref_a[i], sp_neg(ref_b[i]));
				end else begin
					du = sp_add(ref_a[j], sp_neg(ref_b[j]));
					dv = sp_add(ref_b[i], sp_neg(ref_a[i]));
				end
				nv[a] = du;
				nv[b] = dv;
				nv[3 - a - b] = 32'h0;
				p = sp_add(sp_mul(du, ref_a[i]), sp_mul(dv, ref_a[j]));
				for (int k = 0; k < 3; k++) begin
					pl_n[pl_cnt][k] = nv[k];
					pl_sel[pl_cnt][k] = sp_gt(nv[k], 32'h0) ? k : k + 3;
				end
				pl_n[pl_cnt][3] = sp_neg(p);
				pl_cnt++;
			end
		end
	endtask

	function automatic fbits_t plane_dist(int p, fbits_t bx[6], bit opp);
		fbits_t acc, term;
		int c;
		acc = 32'h0;
		for (int k = 0; k < 3; k++) begin
			c = pl_sel[p][k];
			if (opp)
				c = (c + 3) % 6;
			term = sp_mul(pl_n[p][k], bx[c]);
			acc = (k == 0) ? term : sp_add(acc, term);
		end
		return sp_add(acc, pl_n[p][3]);
	endfunction

	function automatic logic [1:0] classify(fbits_t bx[6]);
		fbits_t slack;
		if (apart(bx, hull))
			return CLS_OUTSIDE;
		for (int p = 0; p < pl_cnt; p++) begin
			slack = sp_abs(sp_mul(pl_n[p][3], tol_bits));
			if (sp_gt(plane_dist(p, bx, 1'b0), sp_neg(slack)))
				return CLS_OUTSIDE;
		end
		if (!apart(bx, ref_a) || !apart(bx, ref_b))
			return CLS_OVERLAP;
		for (int p = 0; p < pl_cnt; p++) begin
			slack = sp_abs(sp_mul(pl_n[p][3], tol_bits));
			if (sp_gt(plane_dist(p, bx, 1'b1), slack))
				return CLS_OVERLAP;
		end
		return CLS_INSIDE;
	endfunction

	// ---- stimulus helpers ----
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	function automatic fbits_t small_val();
		int k;
		k = $urandom_range(0, 16) - 8;
		return sp_pack(k < 0, 128'(k < 0 ? -k : k), -1);
	endfunction

	function automatic fbits_t rand_val(bit tame);
		int r;
		r = $urandom_range(0, 99);
		if (tame || r < 70)
			return small_val();
		if (r < 80)
			return $urandom;
		if (r < 84)
			return {1'($urandom_range(0, 1)), 31'd0};
		if (r < 88)
			return {1'($urandom_range(0, 1)), 31'h7F800000};
		if (r < 91)
			return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
		if (r < 95)
			return {1'($urandom_range(0, 1)), 8'h00, 23'($urandom)};
		return small_val() ^ 32'($urandom_range(0, 7));
	endfunction

	task automatic make_box(output fbits_t bx[6], input bit tame);
		fbits_t lo, hi;
		for (int k = 0; k < 3; k++) begin
			lo = rand_val(tame);
			hi = rand_val(tame);
			if (sp_gt(lo, hi)) begin
				bx[k] = hi;
				bx[k + 3] = lo;
			end else begin
				bx[k] = lo;
				bx[k + 3] = hi;
			end
		end
	endtask

	// one input beat; returns after acceptance and the idle gap that follows
	task automatic send_beat(logic [1:0] c, fbits_t bx[6], bit typed, logic [1:0] cls);
		int g;
		@(negedge clk);
		push <= 1'b1;
		cmd <= c;
		box_min_x <= bx[0];
		box_min_y <= bx[1];
		box_min_z <= bx[2];
		box_max_x <= bx[3];
		box_max_y <= bx[4];
		box_max_z <= bx[5];
		@(posedge clk);
		while (full)
			@(posedge clk);
		case (c)
			CMD_FIRST: ref_a = bx;
			CMD_SECOND: begin
				ref_b = bx;
				build_shaft();
			end
			CMD_TEST: class_q.push_back(typed ? cls : classify(bx));
			default: ;
		endcase
		g = gap_len();
		repeat (g) begin
			@(negedge clk);
			push <= 1'b0;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (class_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_eps(fbits_t v);
		drain();
		@(negedge clk);
		eps_we <= 1'b1;
		eps_wdata <= v;
		@(negedge clk);
		eps_we <= 1'b0;
		tol_bits = v;
	endtask

	// ---- result side ----
	initial begin
		int left;
		int r;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (3000) @(negedge clk);
			end else if (left > 0) begin
				pop <= 1'b0;
				left--;
			end else begin
				pop <= 1'b1;
				r = $urandom_range(0, 99);
				if (no_idle || r < 55)
					left = 0;
				else if (r < 90)
					left = $urandom_range(1, 3);
				else if (r < 98)
					left = $urandom_range(4, 15);
				else
					left = $urandom_range(40, 150);
			end
		end
	end

	always @(posedge clk) begin
		logic [1:0] want;
		if (arst_n && pop && !empty) begin
			if (class_q.size() == 0) begin
				$display("%0t: unexpected beat, side_class %0d", $realtime, side_class);
				failed = 1'b1;
			end else begin
				want = class_q.pop_front();
				if (side_class !== want) begin
					$display("%0t: side_class expected %0d actual %0d", $realtime, want,
						side_class);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCHDOG) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---- main sequence ----
	initial begin
		row_t tbl[$];
		fbits_t bx[6];
		fbits_t eps_list[8];
		int n;
		int r;
		tol_bits = EPS_RESET;
		for (int k = 0; k < 6; k++) begin
			ref_a[k] = 0;
			ref_b[k] = 0;
			hull[k] = 0;
		end
		pl_cnt = 0;

		// test before build, unused command, simple and diagonal shafts, reload, specials
		tbl.push_back('{CMD_TEST, '{0, 0, 0, 0, 0, 0}, 1, CLS_OVERLAP});
		tbl.push_back('{CMD_TEST, '{32'h3F800000, 32'h3F800000, 32'h3F800000,
			32'h40000000, 32'h40000000, 32'h40000000}, 1, CLS_OUTSIDE});
		tbl.push_back('{CMD_NONE, '{'1, '1, '1, '1, '1, '1}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_FIRST, '{0, 0, 0, 32'h3F800000, 32'h3F800000, 32'h3F800000},
			0, CLS_INSIDE});
		tbl.push_back('{CMD_SECOND, '{32'h40800000, 0, 0, 32'h40A00000, 32'h3F800000,
			32'h3F800000}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_TEST, '{32'h40000000, 0, 0, 32'h40400000, 32'h3F000000,
			32'h3F000000}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_TEST, '{32'h3F000000, 0, 0, 32'h40000000, 32'h3F000000,
			32'h3F000000}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_TEST, '{32'h40C00000, 0, 0, 32'h40E00000, 32'h3F000000,
			32'h3F000000}, 1, CLS_OUTSIDE});
		tbl.push_back('{CMD_SECOND, '{32'h40800000, 32'h40800000, 0, 32'h40A00000,
			32'h40A00000, 32'h3F800000}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_TEST, '{32'h40000000, 32'h40000000, 0, 32'h40400000,
			32'h40400000, 32'h3F000000}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_TEST, '{32'h40800000, 0, 0, 32'h40A00000, 32'h3F800000,
			32'h3F800000}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_TEST, '{0, 32'h3F800000, 0, 32'h3F800000, 32'h40000000,
			32'h3F800000}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_FIRST, '{32'h41200000, 32'h41200000, 32'h41200000,
			32'h41300000, 32'h41300000, 32'h41300000}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_TEST, '{32'h40000000, 32'h40000000, 0, 32'h40400000,
			32'h40400000, 32'h3F000000}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_TEST, '{FP_QNAN, 0, 0, 32'h3F800000, FP_QNAN, 32'h3F800000},
			0, CLS_INSIDE});
		tbl.push_back('{CMD_TEST, '{32'hFF800000, 32'hFF800000, 32'hFF800000,
			32'h7F800000, 32'h7F800000, 32'h7F800000}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_FIRST, '{32'hFF7FFFFF, 32'h80000001, 0, 32'h7F7FFFFF,
			32'h00000001, 32'h80000000}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_SECOND, '{32'h00000001, 32'h3F800000, 32'h80000000,
			32'h3F800000, 32'h40000000, 32'h00000001}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_TEST, '{0, 0, 0, 0, 0, 0}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_TEST, '{'1, '1, '1, '1, '1, '1}, 0, CLS_INSIDE});
		tbl.push_back('{CMD_TEST, '{32'h7F7FFFFF, 32'h7F7FFFFF, 32'h7F7FFFFF,
			32'h7F7FFFFF, 32'h7F7FFFFF, 32'h7F7FFFFF}, 0, CLS_INSIDE});

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (tbl[i])
			send_beat(tbl[i].c, tbl[i].b, tbl[i].typed, tbl[i].cls);

		eps_list[0] = 32'h00000000;
		eps_list[1] = 32'hFFFFFFFF;
		eps_list[2] = 32'h3F800000;
		eps_list[3] = $urandom;
		eps_list[4] = 32'h7F800000;
		eps_list[5] = 32'h00000001;
		eps_list[6] = 32'h3E000000;
		eps_list[7] = EPS_RESET;

		for (int ph = 0; ph < 8; ph++) begin
			write_eps(eps_list[ph]);
			no_idle = (ph == 2);
			if (ph == 1)
				hold_req = 1'b1;
			n = 0;
			while (n < 135) begin
				r = $urandom_range(0, 99);
				if (r < 85) begin
					make_box(bx, $urandom_range(0, 9) < 9);
					send_beat(CMD_FIRST, bx, 0, CLS_INSIDE);
					make_box(bx, $urandom_range(0, 9) < 9);
					send_beat(CMD_SECOND, bx, 0, CLS_INSIDE);
					n += 2;
					repeat ($urandom_range(2, 8)) begin
						make_box(bx, $urandom_range(0, 1));
						send_beat(CMD_TEST, bx, 0, CLS_INSIDE);
						n++;
					end
				end else begin
					for (int k = 0; k < 6; k++)
						bx[k] = $urandom;
					send_beat(2'($urandom_range(0, 3)), bx, 0, CLS_INSIDE);
					n++;
				end
			end
		end

		drain();
		if (!failed)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
